@@ rtl/salsa_pkg.sv @@
`default_nettype none

package salsa_pkg;

  typedef logic [31:0] word_t;

  // Word 0 sits in bits 31:0, so the packed block lines up with the port fields.
  typedef logic [15:0][31:0] state_t;

  typedef logic [3:0][3:0] lanes_t;

  localparam int STEPS_PER_ROUND = 4;

  // Word indexes of one quarter-round, a in [0] through d in [3].
  function automatic lanes_t qr_lanes(input logic row, input logic [1:0] q);
    lanes_t lanes;
    case ({row, q})
      3'b0_00: lanes = {4'd12, 4'd8,  4'd4,  4'd0};
      3'b0_01: lanes = {4'd1,  4'd13, 4'd9,  4'd5};
      3'b0_10: lanes = {4'd6,  4'd2,  4'd14, 4'd10};
      3'b0_11: lanes = {4'd11, 4'd7,  4'd3,  4'd15};
      3'b1_00: lanes = {4'd3,  4'd2,  4'd1,  4'd0};
      3'b1_01: lanes = {4'd4,  4'd7,  4'd6,  4'd5};
      3'b1_10: lanes = {4'd9,  4'd8,  4'd11, 4'd10};
      3'b1_11: lanes = {4'd14, 4'd13, 4'd12, 4'd15};
      default: lanes = {4'd12, 4'd8,  4'd4,  4'd0};
    endcase
    return lanes;
  endfunction

  function automatic int rot_amt(input int step);
    int amt;
    case (step)
      0:       amt = 7;
      1:       amt = 9;
      2:       amt = 13;
      3:       amt = 18;
      default: amt = 7;
    endcase
    return amt;
  endfunction

endpackage

`default_nettype wire

@@ rtl/salsa_step.sv @@
`default_nettype none

// One add-rotate-xor step, applied to all four quarter-rounds of a round.
module salsa_step #(
  parameter bit ROW  = 1'b0,
  parameter int STEP = 0
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire  salsa_pkg::state_t in_mix,
  input  wire  salsa_pkg::state_t in_orig,
  output logic                   out_valid,
  output salsa_pkg::state_t      out_mix,
  output salsa_pkg::state_t      out_orig
);

  localparam int         R  = salsa_pkg::rot_amt(STEP);
  localparam logic [1:0] SP = 2'(STEP);      // first source
  localparam logic [1:0] S2 = 2'(STEP + 3);  // second source
  localparam logic [1:0] TP = 2'(STEP + 1);  // target

  logic [3:0][31:0]  rot_val;
  logic [3:0][3:0]   tgt;
  salsa_pkg::state_t mix_next;

  for (genvar q = 0; q < 4; q++) begin : g_q
    localparam salsa_pkg::lanes_t L = salsa_pkg::qr_lanes(ROW, 2'(q));
    salsa_pkg::word_t sum;
    assign sum        = in_mix[L[SP]] + in_mix[L[S2]];
    assign rot_val[q] = {sum[31-R:0], sum[31:32-R]};
    assign tgt[q]     = L[TP];
  end

  // Targets of the four quarter-rounds are disjoint words.
  always_comb begin
    mix_next = in_mix;
    for (int q = 0; q < 4; q++) begin
      mix_next[tgt[q]] = in_mix[tgt[q]] ^ rot_val[q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mix  <= mix_next;
      out_orig <= in_orig;
    end
  end

endmodule

`default_nettype wire

@@ rtl/salsa_final.sv @@
`default_nettype none

// Feed-forward: add the original block back, word by word.
module salsa_final (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire  salsa_pkg::state_t in_mix,
  input  wire  salsa_pkg::state_t in_orig,
  output logic                   out_valid,
  output salsa_pkg::state_t      out_sum
);

  salsa_pkg::state_t sum_next;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sum_next[k] = in_mix[k] + in_orig[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/salsa_skid.sv @@
`default_nettype none

// Output register plus one skid entry; upstream ready is registered.
module salsa_skid (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  salsa_pkg::state_t in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output salsa_pkg::state_t      out_data
);

  logic              skid_valid;
  salsa_pkg::state_t skid_data;
  logic              push;

  assign in_ready = !skid_valid;
  assign push     = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= in_data;
      end
    end else if (push) begin
      skid_data <= in_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_push_blocked: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && !out_ready |=> skid_valid && out_valid)
    else $error("transaction into a held output was not kept in skid");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !skid_valid && !push |=> !out_valid)
    else $error("output valid after last transaction was taken");

  a_skid_move: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid entry not moved to output");
`endif

endmodule

`default_nettype wire

@@ rtl/salsa20_block_function_core.sv @@
`default_nettype none

// Channel  Handshake            Payload
// in       in_valid/in_ready    in_words_0_1 .. in_words_14_15 (64b each)
// out      out_valid/out_ready  out_words_0_1 .. out_words_14_15 (64b each)
//
// One block per cycle sustained while out_ready is high. Stages: one per
// quarter-round step, four steps a round, then the feed-forward add stage
// and the output register.
// rst (synchronous) clears only valid bits; data registers are not reset.
// A held output parks one transaction in the skid entry, which freezes the
// whole pipeline; in_ready is low exactly while that entry is full.
module salsa20_block_function_core #(
  parameter int ROUND_COUNT = 20
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [63:0] in_words_0_1,
  input  wire  [63:0] in_words_2_3,
  input  wire  [63:0] in_words_4_5,
  input  wire  [63:0] in_words_6_7,
  input  wire  [63:0] in_words_8_9,
  input  wire  [63:0] in_words_10_11,
  input  wire  [63:0] in_words_12_13,
  input  wire  [63:0] in_words_14_15,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_words_0_1,
  output logic [63:0] out_words_2_3,
  output logic [63:0] out_words_4_5,
  output logic [63:0] out_words_6_7,
  output logic [63:0] out_words_8_9,
  output logic [63:0] out_words_10_11,
  output logic [63:0] out_words_12_13,
  output logic [63:0] out_words_14_15
);

  // Odd counts round up to whole double rounds.
  localparam int ROUNDS = 2 * ((ROUND_COUNT + 1) / 2);
  localparam int NSTEP  = ROUNDS * salsa_pkg::STEPS_PER_ROUND;

  logic              en;
  logic              stg_valid [NSTEP+1];
  salsa_pkg::state_t stg_mix   [NSTEP+1];
  salsa_pkg::state_t stg_orig  [NSTEP+1];
  logic              fin_valid;
  salsa_pkg::state_t fin_sum;
  salsa_pkg::state_t out_state;

  assign in_ready     = en;
  assign stg_valid[0] = in_valid;
  assign stg_mix[0]   = {in_words_14_15, in_words_12_13, in_words_10_11, in_words_8_9,
                         in_words_6_7, in_words_4_5, in_words_2_3, in_words_0_1};
  assign stg_orig[0]  = stg_mix[0];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    salsa_step #(
      .ROW  (((i / salsa_pkg::STEPS_PER_ROUND) % 2) == 1),
      .STEP (i % salsa_pkg::STEPS_PER_ROUND)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[i]),
      .in_mix    (stg_mix[i]),
      .in_orig   (stg_orig[i]),
      .out_valid (stg_valid[i+1]),
      .out_mix   (stg_mix[i+1]),
      .out_orig  (stg_orig[i+1])
    );
  end

  salsa_final u_final (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stg_valid[NSTEP]),
    .in_mix    (stg_mix[NSTEP]),
    .in_orig   (stg_orig[NSTEP]),
    .out_valid (fin_valid),
    .out_sum   (fin_sum)
  );

  salsa_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fin_valid),
    .in_ready  (en),
    .in_data   (fin_sum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_state)
  );

  assign out_words_0_1   = out_state[1:0];
  assign out_words_2_3   = out_state[3:2];
  assign out_words_4_5   = out_state[5:4];
  assign out_words_6_7   = out_state[7:6];
  assign out_words_8_9   = out_state[9:8];
  assign out_words_10_11 = out_state[11:10];
  assign out_words_12_13 = out_state[13:12];
  assign out_words_14_15 = out_state[15:14];

endmodule

`default_nettype wire
